[rtl/bta_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bta_pkg: shared types and codes for the block table allocator
// Request and response beats, table entry record and status codes.
// ----------------------------------------------------------------------------
package bta_pkg;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOFIT    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    localparam logic CFG_POOL_BASE = 1'b0;
    localparam logic CFG_POOL_SIZE = 1'b1;

    localparam logic [31:0] POOL_BASE_RST = 32'd0;
    localparam logic [31:0] POOL_SIZE_RST = 32'd65536;

    typedef struct packed {
        logic        req_type;
        logic [31:0] alloc_size;
        logic [31:0] free_addr;
    } req_t;

    typedef struct packed {
        logic [31:0] block_addr;
        status_t     status;
    } rsp_t;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] length;
        logic        busy;
    } entry_t;

endpackage

`default_nettype wire

[rtl/bta_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bta_cell: one slot of the circulating block table
// Holds one entry; on shift takes its neighbor's entry, on load a fresh one.
// ----------------------------------------------------------------------------
module bta_cell (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   shift_en,
    input  wire bta_pkg::entry_t  d,
    input  wire                   load_en,
    input  wire bta_pkg::entry_t  load_d,
    output bta_pkg::entry_t       q
);

    bta_pkg::entry_t entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (load_en)
        begin
            entry_reg <= load_d;
        end
        else if (shift_en)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

`default_nettype wire

[rtl/block_table_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// block_table_allocator: block allocator with coalescing, first or later free fit
// Table of blocks kept in a ring of cells, scanned one entry per cycle.
// ----------------------------------------------------------------------------
// The table rotates through a ring of MAX_BLOCKS cells; the controller sees
// one entry a cycle at the head and writes it back, changed or not, at the
// tail. A free request makes one pass over the ring (merging and closing up
// the table on the fly); an allocate makes one pass to choose its entry
// and a second one to write it (only the first when nothing fits or the
// table is full), from idle through to done. One request is in flight
// at a time; the next one can be taken while the previous result waits in
// the output register. A register write rebuilds the table as one free
// block spanning the pool once the allocator is idle.
// ----------------------------------------------------------------------------
module block_table_allocator #(
    parameter int MAX_BLOCKS = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_ready,
    input  wire bta_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire                 rsp_ready,
    output bta_pkg::rsp_t       rsp,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [2:0]           paddr,
    input  wire [31:0]          pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = IW + 1;
    localparam logic [IW-1:0] LAST = IW'(MAX_BLOCKS - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_BLOCKS);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_DONE} state_t;

    state_t           state_reg;
    logic             pending_reg;
    logic [31:0]      pool_base_reg;
    logic [31:0]      pool_size_reg;
    logic [CW-1:0]    count_reg;
    logic [IW-1:0]    cyc_reg;
    bta_pkg::req_t    req_reg;
    logic             found_reg, found_next;
    logic             exact_reg, exact_next;
    logic [IW-1:0]    first_idx_reg, first_idx_next;
    logic [31:0]      first_base_reg, first_base_next;
    logic             jfound_reg, jfound_next;
    logic [IW-1:0]    j_idx_reg, j_idx_next;
    logic [31:0]      j_base_reg, j_base_next;
    logic             del_reg;
    logic             act_mark_reg;
    logic             act_split_reg;
    logic [IW-1:0]    mark_idx_reg;
    logic [31:0]      res_addr_reg;
    bta_pkg::status_t res_status_reg;
    logic             rsp_valid_reg;
    bta_pkg::rsp_t    rsp_reg;

    bta_pkg::entry_t  cell_q [MAX_BLOCKS];
    bta_pkg::entry_t  tail_in;
    bta_pkg::entry_t  head;
    bta_pkg::entry_t  nxt;
    bta_pkg::entry_t  load_entry;
    logic             live;
    logic             next_live;
    logic             free_hit;
    logic             merge_now;
    logic             last;
    logic             cfg_wr;
    logic             is_free;
    logic             load_en;
    logic             start;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign prdata    = paddr[2] ? pool_size_reg : pool_base_reg;
    assign req_ready = (state_reg == S_IDLE) && !pending_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign head      = cell_q[0];
    assign nxt       = cell_q[1];
    assign live      = {1'b0, cyc_reg} < count_reg;
    assign next_live = ({1'b0, cyc_reg} + CW'(1)) < count_reg;
    assign last      = cyc_reg == LAST;
    assign is_free   = req_reg.req_type == bta_pkg::REQ_FREE;
    assign load_en   = (state_reg == S_IDLE) && pending_reg;
    assign start     = (state_reg == S_IDLE) && !pending_reg && req_valid;

    always_comb
    begin
        load_entry.base   = pool_base_reg;
        load_entry.length = pool_size_reg;
        load_entry.busy   = 1'b0;
    end

    // ring of cells: shift toward the head, controller feeds the tail
    for (genvar c = 0; c < MAX_BLOCKS; c++)
    begin : g_cell
        bta_pkg::entry_t d;
        if (c == MAX_BLOCKS - 1)
        begin : g_tail
            assign d = tail_in;
        end
        else
        begin : g_mid
            assign d = cell_q[c+1];
        end
        bta_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en ((state_reg == S_SCAN) || (state_reg == S_APPLY)),
            .d        (d),
            .load_en  ((c == 0) && load_en),
            .load_d   (load_entry),
            .q        (cell_q[c])
        );
    end

    always_comb
    begin
        free_hit = (state_reg == S_SCAN) && is_free && !found_reg && live &&
                   (head.base == req_reg.free_addr);
        merge_now = free_hit && next_live && !nxt.busy &&
                    ((head.base + head.length) == nxt.base);

        tail_in = head;
        if (state_reg == S_SCAN && is_free)
        begin
            if (free_hit)
            begin
                tail_in.busy = 1'b0;
                if (merge_now)
                begin
                    tail_in.length = head.length + nxt.length;
                end
            end
            else if (del_reg)
            begin
                // close up the table behind the merged entry
                tail_in = nxt;
            end
        end
        else if (state_reg == S_APPLY)
        begin
            if (act_mark_reg && cyc_reg == mark_idx_reg)
            begin
                tail_in.busy = 1'b1;
            end
            if (act_split_reg && cyc_reg == first_idx_reg)
            begin
                tail_in.base   = head.base + req_reg.alloc_size;
                tail_in.length = head.length - req_reg.alloc_size;
            end
            if (act_split_reg && {1'b0, cyc_reg} == count_reg)
            begin
                tail_in.base   = first_base_reg;
                tail_in.length = req_reg.alloc_size;
                tail_in.busy   = 1'b1;
            end
        end
    end

    // allocate search: first free fit, then the next later free fit if the first is not exact
    always_comb
    begin
        found_next      = found_reg;
        exact_next      = exact_reg;
        first_idx_next  = first_idx_reg;
        first_base_next = first_base_reg;
        jfound_next     = jfound_reg;
        j_idx_next      = j_idx_reg;
        j_base_next     = j_base_reg;
        if (start)
        begin
            found_next  = 1'b0;
            exact_next  = 1'b0;
            jfound_next = 1'b0;
        end
        if (state_reg == S_SCAN && !is_free && live && !head.busy &&
            req_reg.alloc_size != 32'd0 && head.length >= req_reg.alloc_size)
        begin
            if (!found_reg)
            begin
                found_next      = 1'b1;
                exact_next      = head.length == req_reg.alloc_size;
                first_idx_next  = cyc_reg;
                first_base_next = head.base;
            end
            else if (!exact_reg && !jfound_reg)
            begin
                jfound_next = 1'b1;
                j_idx_next  = cyc_reg;
                j_base_next = head.base;
            end
        end
        if (state_reg == S_SCAN && free_hit)
        begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pending_reg    <= 1'b1;
            pool_base_reg  <= bta_pkg::POOL_BASE_RST;
            pool_size_reg  <= bta_pkg::POOL_SIZE_RST;
            count_reg      <= CW'(1);
            cyc_reg        <= '0;
            found_reg      <= 1'b0;
            exact_reg      <= 1'b0;
            jfound_reg     <= 1'b0;
            del_reg        <= 1'b0;
            act_mark_reg   <= 1'b0;
            act_split_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            first_idx_reg  <= '0;
            first_base_reg <= '0;
            j_idx_reg      <= '0;
            j_base_reg     <= '0;
            mark_idx_reg   <= '0;
            res_addr_reg   <= '0;
            res_status_reg <= bta_pkg::ST_OK;
            req_reg        <= '0;
            rsp_reg        <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready && state_reg != S_DONE)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (cfg_wr)
            begin
                if (paddr[2] == bta_pkg::CFG_POOL_SIZE)
                begin
                    pool_size_reg <= pwdata;
                end
                else
                begin
                    pool_base_reg <= pwdata;
                end
                pending_reg <= 1'b1;
            end

            found_reg      <= found_next;
            exact_reg      <= exact_next;
            first_idx_reg  <= first_idx_next;
            first_base_reg <= first_base_next;
            jfound_reg     <= jfound_next;
            j_idx_reg      <= j_idx_next;
            j_base_reg     <= j_base_next;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pending_reg)
                    begin
                        count_reg <= CW'(1);
                        if (!cfg_wr)
                        begin
                            pending_reg <= 1'b0;
                        end
                    end
                    else if (req_valid)
                    begin
                        req_reg       <= req;
                        cyc_reg       <= '0;
                        del_reg       <= 1'b0;
                        act_mark_reg  <= 1'b0;
                        act_split_reg <= 1'b0;
                        state_reg     <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    cyc_reg <= last ? '0 : cyc_reg + IW'(1);
                    if (merge_now)
                    begin
                        del_reg <= 1'b1;
                    end
                    if (last)
                    begin
                        if (is_free)
                        begin
                            state_reg      <= S_DONE;
                            res_addr_reg   <= 32'd0;
                            res_status_reg <= found_next ? bta_pkg::ST_OK
                                                         : bta_pkg::ST_NOTFOUND;
                            if (del_reg)
                            begin
                                count_reg <= count_reg - CW'(1);
                            end
                        end
                        else if (!found_next)
                        begin
                            state_reg      <= S_DONE;
                            res_addr_reg   <= 32'd0;
                            res_status_reg <= bta_pkg::ST_NOFIT;
                        end
                        else if (exact_next || jfound_next)
                        begin
                            res_status_reg <= bta_pkg::ST_OK;
                            res_addr_reg   <= exact_next ? first_base_next : j_base_next;
                            mark_idx_reg   <= exact_next ? first_idx_next : j_idx_next;
                            act_mark_reg   <= 1'b1;
                            state_reg      <= S_APPLY;
                        end
                        else if (count_reg >= FULL_COUNT)
                        begin
                            state_reg      <= S_DONE;
                            res_addr_reg   <= 32'd0;
                            res_status_reg <= bta_pkg::ST_FULL;
                        end
                        else
                        begin
                            res_status_reg <= bta_pkg::ST_OK;
                            res_addr_reg   <= first_base_next;
                            act_split_reg  <= 1'b1;
                            state_reg      <= S_APPLY;
                        end
                    end
                end
                S_APPLY:
                begin
                    cyc_reg <= last ? '0 : cyc_reg + IW'(1);
                    if (last)
                    begin
                        if (act_split_reg)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // hold the result until the output register is free
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_reg.block_addr <= res_addr_reg;
                        rsp_reg.status     <= res_status_reg;
                        rsp_valid_reg      <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                    else
                    begin
                        rsp_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/bta_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bta_checker: port-level checks for the block table allocator
// Watches the request, response and register ports over time.
// ----------------------------------------------------------------------------
module bta_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 req_valid,
    input wire                 req_ready,
    input wire                 rsp_valid,
    input wire                 rsp_ready,
    input wire bta_pkg::rsp_t  rsp,
    input wire                 pready
);

    // a stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    // only a granted allocate carries an address
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != bta_pkg::ST_OK |-> rsp.block_addr == 32'd0)
        else $error("failed request carries an address");

    // one request at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken while busy");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("register port stalled");

endmodule

bind block_table_allocator bta_checker u_bta_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .pready    (pready)
);

`default_nettype wire
